FILE: rtl/mrra_pkg.sv
// Package for the multi-reader ring allocator: payload structs, opcodes, status codes.
// No dependencies.
package mrra_pkg;

    localparam int unsigned DEF_MAX_READERS = 10;
    localparam int unsigned POS_W = 25;
    localparam logic [POS_W-1:0] REGION_RESET = 25'd1048576;

    localparam logic [2:0] OP_ALLOC  = 3'd0;
    localparam logic [2:0] OP_FREE   = 3'd1;
    localparam logic [2:0] OP_DROP   = 3'd2;
    localparam logic [2:0] OP_RESIZE = 3'd3;
    localparam logic [2:0] OP_SPLIT  = 3'd4;
    localparam logic [2:0] OP_ATTACH = 3'd5;
    localparam logic [2:0] OP_DETACH = 3'd6;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BIG      = 3'd1;
    localparam logic [2:0] ST_NOSPACE  = 3'd2;
    localparam logic [2:0] ST_NOTLAST  = 3'd3;
    localparam logic [2:0] ST_ORDER    = 3'd4;
    localparam logic [2:0] ST_NOSLOT   = 3'd5;
    localparam logic [2:0] ST_INACTIVE = 3'd6;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [POS_W-1:0] offset;
        logic [POS_W-1:0] size;
        logic [POS_W-1:0] delta;
        logic [3:0]       consumer;
    } req_t;

    typedef struct packed {
        logic             ok;
        logic [2:0]       status;
        logic [POS_W-1:0] result_offset;
        logic [3:0]       slot_given;
        logic [31:0]      write_tag;
        logic [31:0]      wraps;
    } rsp_t;

endpackage

FILE: rtl/multi_reader_ring_allocator_core.sv
// Top level of the multi-reader ring allocator: sequencer, reader memory, slot stack.
// Depends on mrra_pkg.
//
//  channel | signals                        | beat
//  --------+--------------------------------+-------------------------------
//  request | in_valid, in_ready, in_data    | one opcode with its operands
//  result  | out_valid, out_ready, out_data | one result per request
//  config  | cfg_we, cfg_data               | region size, single cycle
//
// Alloc and resize scan the reader memory one slot a cycle through the single
// read port; free first reads its reader's entry, the others go straight to execute.
// Reset clears the active bits, sets the other scalars to their reset values and
// refills the slot stack; the reader memory needs no clearing since attach writes
// an entry before it is read. A stalled result is held in the output register; the
// next request is taken when it leaves, so one request is in flight at a time.
module multi_reader_ring_allocator_core #(
    parameter int unsigned MAX_READERS = mrra_pkg::DEF_MAX_READERS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  mrra_pkg::req_t               in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output mrra_pkg::rsp_t               out_data,
    input  logic                         cfg_we,
    input  logic [mrra_pkg::POS_W-1:0]   cfg_data
);

    localparam int unsigned IW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int unsigned CW = $clog2(MAX_READERS + 1);
    localparam int unsigned PW = mrra_pkg::POS_W;
    localparam logic [CW-1:0] NREAD = CW'(MAX_READERS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // scalar state
    logic [2:0]    state_reg, state_next;
    logic [PW-1:0] region_reg;
    logic [PW-1:0] wpos_reg, wpos_next;
    logic [PW-1:0] deep_reg, deep_next;
    logic [31:0]   wdone_reg, wdone_next;
    logic [31:0]   wraps_reg, wraps_next;
    logic [MAX_READERS-1:0] act_reg, act_next;
    logic [CW-1:0] fcnt_reg, fcnt_next;
    logic [CW-1:0] acnt_reg, acnt_next;
    logic [IW-1:0] stack_reg [MAX_READERS];
    mrra_pkg::req_t req_reg;
    mrra_pkg::rsp_t rsp_reg, rsp_next;
    logic           ovalid_reg, ovalid_next;

    // scan accumulators
    logic [IW-1:0] idx_reg, idx_next;
    logic [PW:0]   best_reg, best_next;
    logic [31:0]   sum_reg, sum_next;
    logic          chk_reg, chk_next;  // data on the read port belongs to idx-1

    // reader memory: position and read count per slot
    logic [PW+31:0] rmem [MAX_READERS];
    logic [PW+31:0] rdata_reg;
    logic [IW-1:0]  raddr;
    logic           mwe;
    logic [IW-1:0]  waddr;
    logic [PW+31:0] wdata;

    always_ff @(posedge clk)
    begin
        if (mwe)
            rmem[waddr] <= wdata;
        rdata_reg <= rmem[raddr];
    end

    logic [PW-1:0] rd_pos;
    logic [31:0]   rd_cnt;
    assign rd_pos = rdata_reg[PW+31:32];
    assign rd_cnt = rdata_reg[31:0];

    assign in_ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_data  = rsp_reg;

    logic [IW-1:0] cidx;
    logic          cvalid;
    assign cidx   = req_reg.consumer[IW-1:0];
    assign cvalid = ({1'b0, req_reg.consumer} < 5'(MAX_READERS)) && act_reg[cidx];

    // shifted reader candidate for the scan
    logic [PW:0] shift, cand;
    logic [IW-1:0] prev_idx;
    assign shift    = {1'b0, region_reg} + 1'b1;
    assign prev_idx = idx_reg - 1'b1;
    always_comb
    begin
        cand = {1'b0, rd_pos};
        if (rd_pos < wpos_reg || (rd_pos == wpos_reg && rd_cnt == wdone_reg))
            cand = {1'b0, rd_pos} + shift;
    end

    logic [PW:0]   slow;
    logic [31:0]   tot, expct;
    logic [PW:0]   w_sz, w_dl, o_sz;
    logic [IW-1:0] pop_slot;
    always_comb
    begin
        slow  = (best_reg > {1'b0, region_reg}) ? best_reg - shift : best_reg;
        tot   = (acnt_reg == '0) ? wdone_reg : sum_reg;
        expct = (acnt_reg == '0) ? wdone_reg : wdone_reg * 32'(acnt_reg);
        w_sz  = {1'b0, wpos_reg} + {1'b0, req_reg.size};
        w_dl  = {1'b0, wpos_reg} + {1'b0, req_reg.delta};
        o_sz  = {1'b0, req_reg.offset} + {1'b0, req_reg.size};
        pop_slot = stack_reg[fcnt_reg[IW-1:0] - 1'b1];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        wpos_next = wpos_reg; deep_next = deep_reg;
        wdone_next = wdone_reg; wraps_next = wraps_reg;
        act_next = act_reg; fcnt_next = fcnt_reg; acnt_next = acnt_reg;
        idx_next = idx_reg; best_next = best_reg; sum_next = sum_reg;
        chk_next = 1'b0;
        rsp_next = rsp_reg; ovalid_next = ovalid_reg;
        raddr = idx_reg; mwe = 1'b0; waddr = cidx; wdata = '0;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                idx_next  = '0;
                best_next = {1'b0, wpos_reg} + shift;
                sum_next  = '0;
                if (in_valid && in_ready)
                begin
                    rsp_next = '0;
                    if (in_data.opcode == mrra_pkg::OP_ALLOC
                        || in_data.opcode == mrra_pkg::OP_RESIZE)
                        state_next = S_SCAN;
                    else if (in_data.opcode == mrra_pkg::OP_FREE)
                        state_next = S_RD;
                    else
                        state_next = S_EXEC;
                end
            end
            S_SCAN:
            begin
                // read slot idx, fold in slot idx-1
                raddr = idx_reg;
                chk_next = 1'b1;
                if (chk_reg && act_reg[prev_idx])
                begin
                    if (cand < best_reg)
                        best_next = cand;
                    sum_next = sum_reg + rd_cnt;
                end
                if (idx_reg == IW'(MAX_READERS - 1))
                    state_next = S_LAST;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_LAST:
            begin
                if (act_reg[idx_reg])
                begin
                    if (cand < best_reg)
                        best_next = cand;
                    sum_next = sum_reg + rd_cnt;
                end
                state_next = S_EXEC;
            end
            S_RD:
            begin
                raddr = cidx;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                case (req_reg.opcode)
                    mrra_pkg::OP_ALLOC:
                    begin
                        if ({1'b0, req_reg.size} > {1'b0, region_reg})
                            rsp_next.status = mrra_pkg::ST_BIG;
                        else if (slow == {1'b0, wpos_reg} && tot != expct)
                            rsp_next.status = mrra_pkg::ST_NOSPACE;
                        else
                        begin
                            if (deep_reg != '0 && {1'b0, wpos_reg} >= slow)
                                deep_next = '0;
                            if (slow > {1'b0, wpos_reg} && w_sz > slow)
                                rsp_next.status = mrra_pkg::ST_NOSPACE;
                            else if (w_sz > {1'b0, region_reg})
                            begin
                                if ({1'b0, req_reg.size} > slow)
                                    rsp_next.status = mrra_pkg::ST_NOSPACE;
                                else
                                begin
                                    deep_next = wpos_reg;
                                    wraps_next = wraps_reg + 1'b1;
                                    wpos_next = req_reg.size;
                                    wdone_next = wdone_reg + 1'b1;
                                    rsp_next.result_offset = '0;
                                    rsp_next.write_tag = wdone_reg;
                                    rsp_next.wraps = wraps_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                wpos_next = w_sz[PW-1:0];
                                wdone_next = wdone_reg + 1'b1;
                                rsp_next.result_offset = wpos_reg;
                                rsp_next.write_tag = wdone_reg;
                                rsp_next.wraps = wraps_reg;
                            end
                        end
                    end
                    mrra_pkg::OP_FREE:
                    begin
                        if (!cvalid)
                            rsp_next.status = mrra_pkg::ST_INACTIVE;
                        else if (req_reg.offset !=
                                 ((rd_pos == deep_reg) ? '0 : rd_pos))
                            rsp_next.status = mrra_pkg::ST_ORDER;
                        else
                        begin
                            mwe = 1'b1;
                            wdata = {req_reg.offset + req_reg.size, rd_cnt + 32'd1};
                        end
                    end
                    mrra_pkg::OP_DROP:
                    begin
                        if ({1'b0, wpos_reg} != o_sz)
                            rsp_next.status = mrra_pkg::ST_NOTLAST;
                        else
                        begin
                            if (o_sz == {1'b0, deep_reg})
                                deep_next = req_reg.offset;
                            wpos_next = req_reg.offset;
                            wdone_next = wdone_reg - 1'b1;
                        end
                    end
                    mrra_pkg::OP_RESIZE:
                    begin
                        if ({1'b0, wpos_reg} != o_sz)
                            rsp_next.status = mrra_pkg::ST_NOTLAST;
                        else if ((slow > {1'b0, wpos_reg} && w_dl > slow)
                                 || w_dl > {1'b0, region_reg})
                            rsp_next.status = mrra_pkg::ST_NOSPACE;
                        else
                        begin
                            if (deep_reg == wpos_reg)
                                deep_next = w_dl[PW-1:0];
                            wpos_next = w_dl[PW-1:0];
                        end
                    end
                    mrra_pkg::OP_SPLIT:
                        wdone_next = wdone_reg + 1'b1;
                    mrra_pkg::OP_ATTACH:
                    begin
                        if (fcnt_reg == '0)
                            rsp_next.status = mrra_pkg::ST_NOSLOT;
                        else
                        begin
                            fcnt_next = fcnt_reg - 1'b1;
                            rsp_next.slot_given = 4'(pop_slot);
                            mwe = 1'b1;
                            waddr = pop_slot;
                            wdata = {wpos_reg, wdone_reg};
                            act_next[pop_slot] = 1'b1;
                            acnt_next = acnt_reg + 1'b1;
                        end
                    end
                    mrra_pkg::OP_DETACH:
                    begin
                        if (!cvalid)
                            rsp_next.status = mrra_pkg::ST_INACTIVE;
                        else
                        begin
                            mwe = 1'b1;
                            wdata = {wpos_reg, wdone_reg};
                            act_next[cidx] = 1'b0;
                            if (fcnt_reg < NREAD)
                                fcnt_next = fcnt_reg + 1'b1;
                            if (acnt_reg != '0)
                                acnt_next = acnt_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                rsp_next.ok = (rsp_next.status == mrra_pkg::ST_OK);
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // free slot stack push on detach
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_READERS; i++)
                stack_reg[i] <= IW'(MAX_READERS - 1 - i);
        end
        else if (state_reg == S_EXEC && req_reg.opcode == mrra_pkg::OP_DETACH
                 && cvalid && fcnt_reg < NREAD)
            stack_reg[fcnt_reg[IW-1:0]] <= cidx;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_reg <= in_data;
        rsp_reg  <= rsp_next;
        idx_reg  <= idx_next;
        best_reg <= best_next;
        sum_reg  <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            region_reg <= mrra_pkg::REGION_RESET;
            wpos_reg   <= '0;
            deep_reg   <= '0;
            wdone_reg  <= '0;
            wraps_reg  <= '0;
            act_reg    <= '0;
            fcnt_reg   <= NREAD;
            acnt_reg   <= '0;
            ovalid_reg <= 1'b0;
            chk_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            region_reg <= cfg_we ? cfg_data : region_reg;
            wpos_reg   <= wpos_next;
            deep_reg   <= deep_next;
            wdone_reg  <= wdone_next;
            wraps_reg  <= wraps_next;
            act_reg    <= act_next;
            fcnt_reg   <= fcnt_next;
            acnt_reg   <= acnt_next;
            ovalid_reg <= ovalid_next;
            chk_reg    <= chk_next;
        end
    end

    // the active count tracks the active bits
    a_acnt: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(act_reg) == int'(acnt_reg))
        else $error("active count out of step");
    // free plus active slots make up all slots
    a_slots: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fcnt_reg) + int'(acnt_reg) == MAX_READERS)
        else $error("slot accounting broken");
    // a result appears only after an execute step
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result without execution");

endmodule
